// File: rtl/cvg_pkg.sv
// package: shared constants and tables for the circle vertex generator
package cvg_pkg;

  localparam int PHASE_BITS = 16;
  localparam int ANG_W      = 34;
  localparam int XY_W       = 34;
  localparam int MAX_STEPS  = 24;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_lut(input int i);
    logic signed [ANG_W-1:0] v;
    v = '0;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/cvg_div.sv
// module: pipelined restoring divider, one quotient bit per stage
module cvg_div import cvg_pkg::*; #(
  parameter int INDEX_WIDTH = 10,
  parameter int SIDE_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [INDEX_WIDTH-1:0] in_num,
  input  logic [INDEX_WIDTH:0]   in_den,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [PHASE_BITS-1:0]  out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int DW = INDEX_WIDTH + 1;
  localparam int NW = INDEX_WIDTH + PHASE_BITS;
  localparam int NS = NW;

  logic                v_r    [NS+1];
  logic [DW:0]         rem_r  [NS+1];
  logic [NW-1:0]       num_r  [NS+1];
  logic [DW-1:0]       den_r  [NS+1];
  logic [SIDE_W-1:0]   side_r [NS+1];

  assign v_r[0]    = in_valid;
  assign rem_r[0]  = '0;
  assign num_r[0]  = {in_num, {PHASE_BITS{1'b0}}};
  assign den_r[0]  = in_den;
  assign side_r[0] = in_side;

  // each stage shifts in one numerator bit and tries one subtraction
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DW:0] trial;
    logic [DW:0] rem_nxt;
    logic [NW-1:0] num_nxt;
    always_comb begin
      trial   = {rem_r[s][DW-1:0], num_r[s][NW-1]};
      num_nxt = {num_r[s][NW-2:0], 1'b0};
      rem_nxt = trial;
      if (trial >= {1'b0, den_r[s]}) begin
        rem_nxt    = trial - {1'b0, den_r[s]};
        num_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        num_r[s+1]  <= num_nxt;
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = v_r[NS];
  assign out_quo   = num_r[NS][PHASE_BITS-1:0];
  assign out_side  = side_r[NS];

endmodule

// File: rtl/circle_vertex_generator_top.sv
// module: circle vertex generator top level
//  channel | dir | tdata fields (low bit first)                 | tuser
//  in_     | in  | center_x, center_y, radius, vertex_index,    | -
//          |     | num_segments (COORD*3-1+2*INDEX+1 bits, padded)|
//  out_    | out | point_x, point_y                             | is_last, index_error
// one request per cycle unless the output stalls; stages: divider
// (INDEX_WIDTH+16), CORDIC_STEPS rotation stages, then five more stages
// the pipeline advances whenever the output register is empty or taken
// reset clears only valid bits; payload registers are not reset
module circle_vertex_generator_top import cvg_pkg::*; #(
  parameter int COORD_WIDTH  = 16,
  parameter int INDEX_WIDTH  = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // center_x, center_y, radius, vertex_index, num_segments
  input  logic [((3*COORD_WIDTH+2*INDEX_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // point_x, point_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // is_last, index_error
  output logic [1:0] out_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = COORD_WIDTH - 1;
  localparam int IW   = INDEX_WIDTH;
  localparam int OBW  = ((2*COORD_WIDTH+7)/8)*8;
  localparam int SW   = 2*CW + RW + 2;
  localparam int PW   = RW + XY_W + 1;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [RW-1:0]        rad;
    logic                 last;
    logic                 err;
  } side_t;

  logic en;
  logic outv_r;
  assign en        = !outv_r || out_tready;
  assign in_tready = en;

  // field unpack
  logic signed [CW-1:0] f_cx, f_cy;
  logic [RW-1:0]        f_rad;
  logic [IW-1:0]        f_idx;
  logic [IW:0]          f_seg;
  side_t                f_side;
  assign f_cx  = in_tdata[CW-1:0];
  assign f_cy  = in_tdata[2*CW-1:CW];
  assign f_rad = in_tdata[2*CW+RW-1:2*CW];
  assign f_idx = in_tdata[2*CW+RW+IW-1:2*CW+RW];
  assign f_seg = in_tdata[2*CW+RW+2*IW:2*CW+RW+IW];
  always_comb begin
    f_side.cx   = f_cx;
    f_side.cy   = f_cy;
    f_side.rad  = f_rad;
    f_side.err  = ({1'b0, f_idx} >= f_seg);
    f_side.last = (({1'b0, f_idx} + 1'b1) == f_seg);
  end

  // phase = idx * 65536 / seg
  logic                  d_v;
  logic [PHASE_BITS-1:0] d_q;
  logic [SW-1:0]         d_side_raw;
  side_t                 d_side;
  cvg_div #(.INDEX_WIDTH(IW), .SIDE_W(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid && in_tready), .in_num(f_idx), .in_den(f_seg),
    .in_side(f_side),
    .out_valid(d_v), .out_quo(d_q), .out_side(d_side_raw)
  );
  assign d_side = side_t'(d_side_raw);

  // quadrant fold
  logic                    q_v_r;
  logic [1:0]              q_quad_r;
  logic signed [ANG_W-1:0] q_z_r;
  side_t                   q_side_r;
  logic [1:0]              q_quad_nxt;
  logic signed [ANG_W-1:0] q_z_nxt;
  always_comb begin
    q_quad_nxt = d_q[15:14];
    q_z_nxt    = ANG_W'(signed'({1'b0, d_q[13:0]})) <<< 16;
    if (d_q[13]) begin
      q_quad_nxt = d_q[15:14] + 2'd1;
      q_z_nxt    = (ANG_W'(signed'({1'b0, d_q[13:0]})) - ANG_W'(16384)) <<< 16;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= d_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q_quad_r <= q_quad_nxt;
      q_z_r    <= q_z_nxt;
      q_side_r <= d_side;
    end
  end

  // cordic rotation stages
  logic                    c_v    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  c_x    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  c_y    [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] c_z    [CORDIC_STEPS+1];
  logic [1:0]              c_quad [CORDIC_STEPS+1];
  side_t                   c_side [CORDIC_STEPS+1];
  assign c_v[0]    = q_v_r;
  assign c_x[0]    = CORDIC_GAIN;
  assign c_y[0]    = '0;
  assign c_z[0]    = q_z_r;
  assign c_quad[0] = q_quad_r;
  assign c_side[0] = q_side_r;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    logic signed [XY_W-1:0]  dx, dy, x_nxt, y_nxt;
    logic signed [ANG_W-1:0] z_nxt;
    always_comb begin
      dx = c_y[i] >>> i;
      dy = c_x[i] >>> i;
      if (!c_z[i][ANG_W-1]) begin
        x_nxt = c_x[i] - dx; y_nxt = c_y[i] + dy; z_nxt = c_z[i] - atan_lut(i);
      end else begin
        x_nxt = c_x[i] + dx; y_nxt = c_y[i] - dy; z_nxt = c_z[i] + atan_lut(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v[i+1] <= 1'b0;
      end else if (en) begin
        c_v[i+1] <= c_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_x[i+1] <= x_nxt; c_y[i+1] <= y_nxt; c_z[i+1] <= z_nxt;
        c_quad[i+1] <= c_quad[i]; c_side[i+1] <= c_side[i];
      end
    end
  end

  // quarter-turn rotation
  logic                   r_v_r;
  logic signed [XY_W-1:0] r_c_r, r_s_r;
  side_t                  r_side_r;
  logic signed [XY_W-1:0] r_c_nxt, r_s_nxt, lx, ly;
  assign lx = c_x[CORDIC_STEPS];
  assign ly = c_y[CORDIC_STEPS];
  always_comb begin
    case (c_quad[CORDIC_STEPS])
      2'd0:    begin r_c_nxt = lx;  r_s_nxt = ly;  end
      2'd1:    begin r_c_nxt = -ly; r_s_nxt = lx;  end
      2'd2:    begin r_c_nxt = -lx; r_s_nxt = -ly; end
      default: begin r_c_nxt = ly;  r_s_nxt = -lx; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= c_v[CORDIC_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_c_r <= r_c_nxt; r_s_r <= r_s_nxt; r_side_r <= c_side[CORDIC_STEPS];
    end
  end

  // radius products
  logic                 m_v_r;
  logic signed [PW-1:0] m_px_r, m_py_r;
  side_t                m_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= r_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_px_r   <= PW'(signed'({1'b0, r_side_r.rad})) * PW'(r_c_r);
      m_py_r   <= PW'(signed'({1'b0, r_side_r.rad})) * PW'(r_s_r);
      m_side_r <= r_side_r;
    end
  end

  // round and add centre
  localparam int AW = PW - 30 + 1;
  logic                 a_v_r;
  logic signed [AW-1:0] a_x_r, a_y_r;
  side_t                a_side_r;
  logic signed [PW-1:0] rx, ry;
  assign rx = m_px_r + (PW'(1) <<< 29);
  assign ry = m_py_r + (PW'(1) <<< 29);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= m_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= AW'(rx >>> 30) + AW'(m_side_r.cx);
      a_y_r    <= AW'(ry >>> 30) + AW'(m_side_r.cy);
      a_side_r <= m_side_r;
    end
  end

  // saturate and output register
  function automatic logic [CW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi, lo;
    hi = AW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - AW'(1);
    if (v > hi)      return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else             return v[CW-1:0];
  endfunction

  logic [CW-1:0] ox_r, oy_r;
  logic [1:0]    ou_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (en) begin
      outv_r <= a_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= a_side_r.err ? '0 : sat(a_x_r);
      oy_r <= a_side_r.err ? '0 : sat(a_y_r);
      ou_r <= {a_side_r.err, a_side_r.last && !a_side_r.err};
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = OBW'({oy_r, ox_r});
  assign out_tuser  = ou_r;

endmodule

// File: rtl/cvg_checker.sv
// checker: port-level properties of the circle vertex generator
module cvg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [1:0] out_tuser
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  // error and last never together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1])) else $error("last with error");
  // ready follows output register
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stalled while empty");
  // nothing out right after reset
  a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_tvalid)
    else $error("valid after reset");
endmodule

bind circle_vertex_generator_top cvg_checker u_cvg_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tuser(out_tuser)
);
